@@ rtl/core/lfu_evicting_key_cache_unit_assert.svh @@
// ----------------------------------------------------------------------------
// lfu evicting key cache assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef LFU_EVICTING_KEY_CACHE_UNIT_ASSERT_SVH
`define LFU_EVICTING_KEY_CACHE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/lfuc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfuc_pkg
// shared widths, operation codes and record types of the lfu key cache
// ----------------------------------------------------------------------------
package lfuc_pkg;

    localparam int CAPACITY = 16;
    localparam int POP_BITS = 16;
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 64;
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int RANK_W   = IDX_W;

    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd2;

    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0]    CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [POP_BITS-1:0] POP_MAX  = '1;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [PAY_W-1:0]    payload;
        logic [POP_BITS-1:0] pop;
        logic [RANK_W-1:0]   rank;
    } entry_t;

    typedef struct packed {
        logic              clear;
        logic              take;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
    } scan_ctl_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        entry_t            entry;
    } scan_res_t;

endpackage

@@ rtl/core/lfuc_entry_mem.sv @@
// ----------------------------------------------------------------------------
// lfuc_entry_mem
// entry record store: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lfuc_entry_mem
    import lfuc_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/lfuc_scan.sv @@
// ----------------------------------------------------------------------------
// lfuc_scan
// tracks the newest matching entry while the store is walked
// ----------------------------------------------------------------------------
module lfuc_scan
    import lfuc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  scan_ctl_t ctl,
    input  entry_t    rd_data,
    output scan_res_t res
);

    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] idx_reg;
    entry_t           best_reg;
    logic             hit;

    // lower rank is newer
    assign hit = ctl.take && (rd_data.key == ctl.key)
                 && (!found_reg || (rd_data.rank < best_reg.rank));

    always_comb
    begin
        found_next = found_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (hit)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            best_reg <= rd_data;
            idx_reg  <= ctl.idx;
        end
    end

    assign res.found = found_reg;
    assign res.idx   = idx_reg;
    assign res.entry = best_reg;

endmodule

@@ rtl/core/lfu_evicting_key_cache_unit.sv @@
// ----------------------------------------------------------------------------
// lfu_evicting_key_cache_unit
// keyed cache with least-frequently-used eviction, walked in a record store
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command per beat: tuser is the operation (add, delete,
//   find), tdata the key and the payload to store on add.
//   m_axis returns exactly one result beat per command: tuser holds status
//   and evicted flags, tdata the found payload and the evicted key.
// sequence:
//   find walks the store (one read per cycle), then writes the popularity
//   back on a hit; delete adds a second 16-entry walk to close the age
//   ranks; add walks once to age the entries, then writes.
//   add on a full cache and unknown codes answer without a walk.
//   the store's single read port sets the walk length; one command is in
//   flight at a time.
// reset:
//   all entries invalid and the fill count zero; no clearing pass is needed.
// stall:
//   a result waits in the output register while the next command is taken;
//   a second result waits in its final state until the receiver frees it.
// ----------------------------------------------------------------------------
`include "lfu_evicting_key_cache_unit_assert.svh"

module lfu_evicting_key_cache_unit
    import lfuc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [KEY_W+PAY_W-1:0]   s_axis_tdata,  // key, payload_in
    input  logic [FUNC_W-1:0]        s_axis_tuser,  // func
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [PAY_W+KEY_W-1:0]   m_axis_tdata,  // payload_out, evicted_key
    output logic [1:0]               m_axis_tuser   // status, evicted
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SWEEP = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [FUNC_W-1:0]       func_reg, func_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAY_W-1:0]        pay_reg, pay_next;
    logic [CAPACITY-1:0]     valid_reg, valid_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]        iss_idx_reg, iss_idx_next;
    logic                    iss_on_reg, iss_on_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    status_reg, status_next;
    logic                    evicted_reg, evicted_next;
    logic [PAY_W-1:0]        pout_reg, pout_next;
    logic                    m_valid_reg, m_valid_next;
    logic [PAY_W+KEY_W-1:0]  m_data_reg, m_data_next;
    logic [1:0]              m_user_reg, m_user_next;

    logic                    in_fire;
    logic                    free_any;
    logic [IDX_W-1:0]        free_idx;
    logic                    walking;
    logic                    rd_last;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    entry_t                  wr_data;
    entry_t                  rd_data;
    scan_ctl_t               scan_ctl;
    scan_res_t               scan_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign walking       = (state_reg == ST_SCAN) || (state_reg == ST_SWEEP);
    assign rd_last       = rd_vld_reg && (rd_idx_reg == LAST_IDX);

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    lfuc_entry_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (iss_idx_reg),
        .rd_data (rd_data)
    );

    assign scan_ctl.clear = in_fire;
    assign scan_ctl.take  = (state_reg == ST_SCAN) && rd_vld_reg && valid_reg[rd_idx_reg];
    assign scan_ctl.idx   = rd_idx_reg;
    assign scan_ctl.key   = key_reg;

    lfuc_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .rd_data (rd_data),
        .res     (scan_res)
    );

    // store write-back: rank ageing (add) or gap closing (delete) during a sweep, record write at the end
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_idx_reg;
        wr_data = rd_data;
        if ((state_reg == ST_SWEEP) && rd_vld_reg && valid_reg[rd_idx_reg])
        begin
            if (func_reg == FUNC_ADD)
            begin
                wr_en        = 1'b1;
                wr_data.rank = rd_data.rank + 1'b1;
            end
            else if (rd_data.rank > scan_res.entry.rank)
            begin
                wr_en        = 1'b1;
                wr_data.rank = rd_data.rank - 1'b1;
            end
        end
        else if (state_reg == ST_WRITE)
        begin
            if (func_reg == FUNC_ADD)
            begin
                wr_en           = 1'b1;
                wr_addr         = free_idx_reg;
                wr_data.key     = key_reg;
                wr_data.payload = pay_reg;
                wr_data.pop     = '0;
                wr_data.rank    = '0;
            end
            else if ((func_reg == FUNC_FIND) && scan_res.found)
            begin
                wr_en   = 1'b1;
                wr_addr = scan_res.idx;
                wr_data = scan_res.entry;
                if (scan_res.entry.pop != POP_MAX)
                begin
                    wr_data.pop = scan_res.entry.pop + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        valid_next    = valid_reg;
        cnt_next      = cnt_reg;
        free_idx_next = free_idx_reg;
        iss_idx_next  = iss_idx_reg;
        iss_on_next   = iss_on_reg;
        rd_vld_next   = walking && iss_on_reg;
        rd_idx_next   = iss_idx_reg;
        status_next   = status_reg;
        evicted_next  = evicted_reg;
        pout_next     = pout_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        // read issue while walking
        if (walking && iss_on_reg)
        begin
            if (iss_idx_reg == LAST_IDX)
            begin
                iss_on_next = 1'b0;
            end
            else
            begin
                iss_idx_next = iss_idx_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    func_next    = s_axis_tuser;
                    key_next     = s_axis_tdata[KEY_W-1:0];
                    pay_next     = s_axis_tdata[KEY_W+PAY_W-1:KEY_W];
                    status_next  = 1'b0;
                    evicted_next = 1'b0;
                    pout_next    = '0;
                    iss_idx_next = '0;
                    priority if (s_axis_tuser == FUNC_ADD)
                    begin
                        if ((cnt_reg >= CNT_FULL) || !free_any)
                        begin
                            // new entry is both least popular and newest
                            evicted_next = 1'b1;
                            state_next   = ST_DONE;
                        end
                        else
                        begin
                            free_idx_next = free_idx;
                            iss_on_next   = 1'b1;
                            state_next    = ST_SWEEP;
                        end
                    end
                    else if ((s_axis_tuser == FUNC_DEL) || (s_axis_tuser == FUNC_FIND))
                    begin
                        iss_on_next = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_SWEEP:
            begin
                if (rd_last)
                begin
                    state_next = (func_reg == FUNC_ADD) ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                priority if (func_reg == FUNC_ADD)
                begin
                    valid_next[free_idx_reg] = 1'b1;
                    cnt_next                 = cnt_reg + 1'b1;
                    state_next               = ST_DONE;
                end
                else if (!scan_res.found)
                begin
                    status_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else if (func_reg == FUNC_FIND)
                begin
                    pout_next  = scan_res.entry.payload;
                    state_next = ST_DONE;
                end
                else
                begin
                    // delete: drop the entry, then close the gap in ranks
                    valid_next[scan_res.idx] = 1'b0;
                    if (cnt_reg != '0)
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                    iss_idx_next = '0;
                    iss_on_next  = 1'b1;
                    state_next   = ST_SWEEP;
                end
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(evicted_reg ? key_reg : {KEY_W{1'b0}}), pout_reg};
                    m_user_next  = {evicted_reg, status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            iss_on_reg  <= 1'b0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            iss_on_reg  <= iss_on_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        free_idx_reg <= free_idx_next;
        iss_idx_reg  <= iss_idx_next;
        rd_idx_reg   <= rd_idx_next;
        status_reg   <= status_next;
        evicted_reg  <= evicted_next;
        pout_reg     <= pout_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `ASSERT_ALWAYS(a_cnt_tracks_valid, clk, rst_n, $countones(valid_reg) == cnt_reg)
    `ASSERT_ALWAYS(a_cnt_bounded, clk, rst_n, cnt_reg <= CNT_FULL)
    `ASSERT_IMPLY(a_scan_no_write, clk, rst_n, state_reg == ST_SCAN, !wr_en)
    `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_fire, !s_axis_tready)

endmodule

@@ test/lfu_evicting_key_cache_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_evicting_key_cache_unit_tb
// drives add, delete and find commands into the key cache and checks every
// result beat against a behavioural copy of the cache kept in the bench
// ----------------------------------------------------------------------------
module lfu_evicting_key_cache_unit_tb;
    import lfuc_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;
    localparam logic              STAT_MISS  = 1'b1;
    localparam int                HOLD_CYCLES = 400;
    localparam int                STALL_LIMIT = 4000;
    localparam int                TAIL_CYCLES = 60;
    localparam int                POOL_N      = 12;

    typedef struct packed {
        logic             status;
        logic [PAY_W-1:0] payload;
        logic             evicted;
        logic [KEY_W-1:0] ev_key;
    } cache_reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [KEY_W+PAY_W-1:0] s_axis_tdata;   // key, payload_in
    logic [FUNC_W-1:0]      s_axis_tuser;   // func
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [PAY_W+KEY_W-1:0] m_axis_tdata;   // payload_out, evicted_key
    logic [1:0]             m_axis_tuser;   // status, evicted

    // bench copy of the cache
    logic                slot_used [CAPACITY];
    logic [KEY_W-1:0]    slot_key  [CAPACITY];
    logic [PAY_W-1:0]    slot_data [CAPACITY];
    logic [POP_BITS-1:0] slot_hits [CAPACITY];
    logic [RANK_W-1:0]   slot_age  [CAPACITY];
    logic [CNT_W-1:0]    fill_level;

    cache_reply_t     pending_replies[$];
    logic [KEY_W-1:0] seed_keys [CAPACITY];
    logic [PAY_W-1:0] seed_data [CAPACITY];
    logic [KEY_W-1:0] key_pool  [POOL_N];
    int               fail_count;
    int               stall_cycles;
    logic             tx_idle_on;
    logic             rx_idle_on;
    logic             hold_pending;

    lfu_evicting_key_cache_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // slot of the newest valid entry holding the key, or -1
    function automatic int newest_match(input logic [KEY_W-1:0] k);
        int best;
        best = -1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_used[i] && slot_key[i] == k)
            begin
                if (best < 0 || slot_age[i] < slot_age[best])
                    best = i;
            end
        end
        return best;
    endfunction

    function automatic cache_reply_t lfu_predict(input logic [FUNC_W-1:0] op,
                                                 input logic [KEY_W-1:0]  k,
                                                 input logic [PAY_W-1:0]  pay);
        cache_reply_t      r;
        int                hit;
        int                spot;
        logic [RANK_W-1:0] gone_age;
        r   = '0;
        hit = newest_match(k);
        case (op)
            FUNC_ADD:
            begin
                spot = -1;
                for (int i = CAPACITY - 1; i >= 0; i--)
                    if (!slot_used[i])
                        spot = i;
                // the newcomer has no hits and is newest, so it is the one dropped
                if (fill_level >= CNT_FULL || spot < 0)
                begin
                    r.evicted = 1'b1;
                    r.ev_key  = k;
                end
                else
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (slot_used[i])
                            slot_age[i] = slot_age[i] + 1'b1;
                    slot_used[spot] = 1'b1;
                    slot_key[spot]  = k;
                    slot_data[spot] = pay;
                    slot_hits[spot] = '0;
                    slot_age[spot]  = '0;
                    fill_level      = fill_level + 1'b1;
                end
            end
            FUNC_DEL:
            begin
                if (hit < 0)
                    r.status = STAT_MISS;
                else
                begin
                    gone_age       = slot_age[hit];
                    slot_used[hit] = 1'b0;
                    for (int i = 0; i < CAPACITY; i++)
                        if (slot_used[i] && slot_age[i] > gone_age)
                            slot_age[i] = slot_age[i] - 1'b1;
                    if (fill_level != '0)
                        fill_level = fill_level - 1'b1;
                end
            end
            FUNC_FIND:
            begin
                if (hit < 0)
                    r.status = STAT_MISS;
                else
                begin
                    if (slot_hits[hit] != POP_MAX)
                        slot_hits[hit] = slot_hits[hit] + 1'b1;
                    r.payload = slot_data[hit];
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    task automatic issue_cmd(input logic [FUNC_W-1:0] op,
                             input logic [KEY_W-1:0]  k,
                             input logic [PAY_W-1:0]  pay);
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pay, k};
        do @(posedge clk); while (!s_axis_tready);
        pending_replies.push_back(lfu_predict(op, k, pay));
    endtask

    // sender stays quiet until every outstanding result has been returned
    task automatic drain_replies();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_replies.size() != 0);
    endtask

    task automatic note_failure(input string what, input logic [PAY_W-1:0] want,
                                input logic [PAY_W-1:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
    endtask

    task automatic test_empty_cache();
        issue_cmd(FUNC_FIND, 32'h0000_0000, '1);
        issue_cmd(FUNC_DEL, 32'h8000_0000, '0);
    endtask

    task automatic test_fill_and_overflow();
        seed_keys[0] = 32'h8000_0000;
        seed_keys[1] = 32'h7FFF_FFFF;
        seed_keys[2] = 32'h0000_0000;
        seed_keys[3] = 32'hFFFF_FFFF;
        seed_data[0] = '0;
        seed_data[1] = '1;
        seed_data[2] = 64'h5555_5555_5555_5555;
        seed_data[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        for (int i = 4; i < CAPACITY; i++)
        begin
            seed_keys[i] = 32'h1000 + i;
            seed_data[i] = {$urandom(), $urandom()};
        end
        for (int i = 0; i < CAPACITY; i++)
            issue_cmd(FUNC_ADD, seed_keys[i], seed_data[i]);
        // cache full: the new key comes straight back as evicted
        issue_cmd(FUNC_ADD, 32'h0BAD_CAFE, '1);
        issue_cmd(FUNC_NONE, 32'hFFFF_FFFF, '1);
    endtask

    task automatic test_lookup_and_remove();
        issue_cmd(FUNC_FIND, seed_keys[0], '0);
        issue_cmd(FUNC_FIND, seed_keys[CAPACITY-1], '0);
        issue_cmd(FUNC_DEL, seed_keys[7], '0);
        // duplicate key: the newer copy must shadow the older one
        issue_cmd(FUNC_ADD, seed_keys[3], 64'h0123_4567_89AB_CDEF);
        issue_cmd(FUNC_FIND, seed_keys[3], '0);
        issue_cmd(FUNC_DEL, seed_keys[3], '0);
        issue_cmd(FUNC_FIND, seed_keys[3], '0);
    endtask

    task automatic test_random_mix(input int n_items);
        logic [FUNC_W-1:0] op;
        logic [KEY_W-1:0]  k;
        logic [PAY_W-1:0]  pay;
        int                roll;
        int                add_pct;
        int                del_pct;
        int                live[$];
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_N; i++)
            key_pool[i] = $urandom();
        for (int n = 0; n < n_items; n++)
        begin
            // steer the fill level so that both empty and full behaviour recur
            if (fill_level < 4)
            begin
                add_pct = 55;
                del_pct = 15;
            end
            else if (fill_level >= CAPACITY - 2)
            begin
                add_pct = 25;
                del_pct = 35;
            end
            else
            begin
                add_pct = 38;
                del_pct = 25;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                op = FUNC_NONE;
            else if (roll < 3 + add_pct)
                op = FUNC_ADD;
            else if (roll < 3 + add_pct + del_pct)
                op = FUNC_DEL;
            else
                op = FUNC_FIND;
            live.delete();
            for (int i = 0; i < CAPACITY; i++)
                if (slot_used[i])
                    live.push_back(i);
            roll = $urandom_range(0, 99);
            if (op != FUNC_ADD && live.size() != 0 && roll < 55)
                k = slot_key[live[$urandom_range(0, live.size() - 1)]];
            else if (roll < 85)
                k = key_pool[$urandom_range(0, POOL_N - 1)];
            else
                k = $urandom();
            case ($urandom_range(0, 9))
                0:       pay = '0;
                1:       pay = '1;
                default: pay = {$urandom(), $urandom()};
            endcase
            issue_cmd(op, k, pay);
        end
    endtask

    task automatic test_backpressure();
        tx_idle_on   = 1'b0;
        hold_pending = 1'b1;
        repeat (2) @(posedge clk);
        test_random_mix(12);
        drain_replies();
        tx_idle_on = 1'b1;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        cache_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_replies.size() == 0)
                note_failure("unexpected beat", '0, m_axis_tdata[PAY_W-1:0]);
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser[0] !== want.status)
                    note_failure("status", PAY_W'(want.status), PAY_W'(m_axis_tuser[0]));
                if (m_axis_tdata[PAY_W-1:0] !== want.payload)
                    note_failure("payload_out", want.payload, m_axis_tdata[PAY_W-1:0]);
                if (m_axis_tuser[1] !== want.evicted)
                    note_failure("evicted", PAY_W'(want.evicted), PAY_W'(m_axis_tuser[1]));
                if (m_axis_tdata[PAY_W+KEY_W-1:PAY_W] !== want.ev_key)
                    note_failure("evicted_key", PAY_W'(want.ev_key),
                                 PAY_W'(m_axis_tdata[PAY_W+KEY_W-1:PAY_W]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles = 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_ADD;
        fail_count    = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        hold_pending  = 1'b0;
        fill_level    = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_data[i] = '0;
            slot_hits[i] = '0;
            slot_age[i]  = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_cache();
        test_fill_and_overflow();
        test_lookup_and_remove();
        drain_replies();
        test_backpressure();
        test_random_mix(1650);
        drain_replies();
        // closing stretch runs flat out on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_mix(260);

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
            note_failure("missing beats", PAY_W'(pending_replies.size()), '0);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
